@@ src/poc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// poc_pkg
// Shared types and constants for the prelogin encryption option check.
// ----------------------------------------------------------------------------
package poc_pkg;

    localparam int UNIT_W       = 17;     // wide enough for a 16-bit offset plus length
    localparam int HEADER_BYTES = 8;
    localparam int ENTRY_BYTES  = 5;
    localparam int ENTRY_TAIL   = 4;      // bytes after the type byte in one entry

    localparam logic [7:0] END_TYPE     = 8'hff;
    localparam logic [7:0] ENCRYPT_TYPE = 8'h01;
    localparam logic [7:0] FLAG_RESET   = 8'h02;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic uses_encryption;
    } t_out_word;

    // shared adder / comparator result
    typedef struct packed {
        logic [UNIT_W-1:0] sum;
        logic              gt;
        logic              ge;
    } t_alu_res;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_ENT,
        S_TYPE,
        S_OFFH,
        S_OFFL,
        S_LENH,
        S_LENL,
        S_RNG1,
        S_RNG2,
        S_FRD,
        S_FLAG,
        S_NEXT,
        S_PUT
    } t_state;

endpackage
`default_nettype wire

@@ src/poc_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// poc_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface poc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/poc_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// poc_store
// Packet byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module poc_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ src/poc_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// poc_alu
// Shared add and compare unit: sum = a + b, tested against a limit.
// ----------------------------------------------------------------------------
module poc_alu (
    input  wire logic [poc_pkg::UNIT_W-1:0] i_a,
    input  wire logic [poc_pkg::UNIT_W-1:0] i_b,
    input  wire logic [poc_pkg::UNIT_W-1:0] i_limit,
    output poc_pkg::t_alu_res               o_res
);
    logic [poc_pkg::UNIT_W-1:0] sum;

    assign sum      = i_a + i_b;
    assign o_res.sum = sum;
    assign o_res.gt  = (sum >  i_limit);
    assign o_res.ge  = (sum >= i_limit);
endmodule
`default_nettype wire

@@ src/prelogin_encryption_option_check_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prelogin_encryption_option_check_core
// Collects one prelogin reply packet and reports whether it asks for encryption.
//
// Input channel i_in carries one packet byte per word, with last_byte marking
// the final byte. Bytes are taken one per cycle and written to the packet
// store; bytes past MAX_PACKET_BYTES are dropped, the last mark still counts.
// After the last byte the sequencer walks the option table with one shared
// adder/comparator and the store's single read port. Ready is low during the
// walk. The walk has a setup step, then for each option entry reads the type,
// offset and length, checks the range and, for an encryption entry with a nonzero
// length, reads the flag byte; a malformed table stops at the first bad entry.
// One word on o_out (uses_encryption) follows each packet. The result sits in
// an output register, so loading of the next packet may start while it waits;
// if it has still not been taken when the next walk ends, the block holds
// in its final state with ready low until it is.
// Reset (i_rst_n low, synchronous) empties the byte count and the output
// register; the store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module prelogin_encryption_option_check_core #(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    poc_stream_if.sink   i_in,
    poc_stream_if.source o_out
);
    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int AW = $clog2(MAX_PACKET_BYTES);
    localparam int UW = poc_pkg::UNIT_W;

    poc_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_plen,  n_plen;
    logic [CW-1:0]   r_pos,   n_pos;
    logic [CW-1:0]   r_addr,  n_addr;
    logic [7:0]      r_type,  n_type;
    logic [15:0]     r_off,   n_off;
    logic [15:0]     r_len,   n_len;
    logic [7:0]      r_flag,  n_flag;
    logic            r_ok,    n_ok;
    logic            r_ov,    n_ov;
    logic            r_res,   n_res;

    logic [UW-1:0]   alu_a, alu_b, alu_lim;
    poc_pkg::t_alu_res alu;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      mem_q;
    logic            in_acc;
    logic            room;

    assign in_acc = i_in.valid && i_in.ready;
    assign room   = (r_count < CW'(MAX_PACKET_BYTES));

    poc_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_limit (alu_lim),
        .o_res   (alu)
    );

    poc_store #(
        .DEPTH (MAX_PACKET_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.data.data_byte),
        .i_raddr (rd_addr),
        .o_rdata (mem_q)
    );

    // flag fetch takes its address from the shared unit, all else from the walk pointer
    assign rd_addr = (r_state == poc_pkg::S_FRD) ? alu.sum[AW-1:0] : r_addr[AW-1:0];

    assign i_in.ready                = (r_state == poc_pkg::S_LOAD);
    assign o_out.valid               = r_ov;
    assign o_out.data.uses_encryption = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= poc_pkg::S_LOAD;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plen <= n_plen;
        r_pos  <= n_pos;
        r_addr <= n_addr;
        r_type <= n_type;
        r_off  <= n_off;
        r_len  <= n_len;
        r_flag <= n_flag;
        r_ok   <= n_ok;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_plen  = r_plen;
        n_pos   = r_pos;
        n_addr  = r_addr;
        n_type  = r_type;
        n_off   = r_off;
        n_len   = r_len;
        n_flag  = r_flag;
        n_ok    = r_ok;
        n_res   = r_res;
        n_ov    = r_ov && !o_out.ready;
        alu_a   = UW'(r_pos);
        alu_b   = '0;
        alu_lim = UW'(r_plen);

        case (r_state)
            poc_pkg::S_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_in.data.last_byte) begin
                        n_state = poc_pkg::S_START;
                    end
                end
            end
            poc_pkg::S_START: begin
                // at least one payload byte needed beyond the header
                alu_a   = UW'(r_count);
                alu_lim = UW'(poc_pkg::HEADER_BYTES);
                n_plen  = r_count - CW'(poc_pkg::HEADER_BYTES);
                n_pos   = '0;
                n_addr  = CW'(poc_pkg::HEADER_BYTES);
                n_flag  = poc_pkg::FLAG_RESET;
                n_ok    = alu.gt;
                n_state = alu.gt ? poc_pkg::S_ENT : poc_pkg::S_PUT;
            end
            poc_pkg::S_ENT: begin
                if (alu.ge) begin
                    n_ok    = 1'b0;
                    n_state = poc_pkg::S_PUT;
                end else begin
                    n_addr  = r_addr + CW'(1);
                    n_state = poc_pkg::S_TYPE;
                end
            end
            poc_pkg::S_TYPE: begin
                alu_b  = UW'(poc_pkg::ENTRY_TAIL);
                n_type = mem_q;
                if (mem_q == poc_pkg::END_TYPE) begin
                    n_state = poc_pkg::S_PUT;
                end else if (alu.ge) begin
                    n_ok    = 1'b0;
                    n_state = poc_pkg::S_PUT;
                end else begin
                    n_addr  = r_addr + CW'(1);
                    n_state = poc_pkg::S_OFFH;
                end
            end
            poc_pkg::S_OFFH: begin
                n_off[15:8] = mem_q;
                n_addr      = r_addr + CW'(1);
                n_state     = poc_pkg::S_OFFL;
            end
            poc_pkg::S_OFFL: begin
                n_off[7:0] = mem_q;
                n_addr     = r_addr + CW'(1);
                n_state    = poc_pkg::S_LENH;
            end
            poc_pkg::S_LENH: begin
                n_len[15:8] = mem_q;
                n_addr      = r_addr + CW'(1);
                n_state     = poc_pkg::S_LENL;
            end
            poc_pkg::S_LENL: begin
                n_len[7:0] = mem_q;
                n_state    = poc_pkg::S_RNG1;
            end
            poc_pkg::S_RNG1: begin
                alu_a = UW'(r_off);
                if (alu.gt) begin
                    n_ok    = 1'b0;
                    n_state = poc_pkg::S_PUT;
                end else begin
                    n_state = poc_pkg::S_RNG2;
                end
            end
            poc_pkg::S_RNG2: begin
                alu_a = UW'(r_off);
                alu_b = UW'(r_len);
                if (alu.gt) begin
                    n_ok    = 1'b0;
                    n_state = poc_pkg::S_PUT;
                end else if (r_type == poc_pkg::ENCRYPT_TYPE && r_len != 16'd0) begin
                    n_state = poc_pkg::S_FRD;
                end else begin
                    n_state = poc_pkg::S_NEXT;
                end
            end
            poc_pkg::S_FRD: begin
                alu_a   = UW'(r_off);
                alu_b   = UW'(poc_pkg::HEADER_BYTES);
                n_state = poc_pkg::S_FLAG;
            end
            poc_pkg::S_FLAG: begin
                n_flag  = mem_q;
                n_state = poc_pkg::S_NEXT;
            end
            poc_pkg::S_NEXT: begin
                alu_b   = UW'(poc_pkg::ENTRY_BYTES);
                n_pos   = alu.sum[CW-1:0];
                n_state = poc_pkg::S_ENT;
            end
            poc_pkg::S_PUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_res   = r_ok && (r_flag != 8'd0);
                    n_count = '0;
                    n_state = poc_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = poc_pkg::S_LOAD;
            end
        endcase
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PACKET_BYTES))
        else $error("byte count beyond store capacity");

    a_last_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.last_byte) |=> (r_state == poc_pkg::S_START))
        else $error("last byte did not start the table walk");

    a_result_from_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == poc_pkg::S_PUT))
        else $error("result posted outside the final state");

    a_flag_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == poc_pkg::S_FRD) |-> (alu.sum < UW'(r_count)))
        else $error("flag read outside the stored packet");

    a_entry_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == poc_pkg::S_OFFH) |-> (r_addr < r_count))
        else $error("entry read outside the stored packet");
endmodule
`default_nettype wire

@@ tb/sv/prelogin_encryption_option_check_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prelogin_encryption_option_check_core_tb
// Streams prelogin reply packets into the block and checks each
// uses_encryption word against a behavioural walk of the option table.
// A short directed set covers short packets, missing end marks, out-of-range
// options, zero-length and repeated encryption entries and a packet past the
// store capacity. Random packets follow, mostly well-formed tables with random
// content, some broken or plain noise. Sender bursts and receiver stalls vary.
// ----------------------------------------------------------------------------
module prelogin_encryption_option_check_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // small store so that overflowing packets stay cheap
    localparam int CAPACITY      = 64;
    localparam int RANDOM_BYTES  = 320;
    localparam int SETTLE_CYCLES = 200;

    localparam logic [7:0] PLAIN_TYPE = 8'h00;
    localparam logic [7:0] OTHER_TYPE = 8'h02;

    // ------------------------------------------------------------------------
    // Holds the bytes of the packet in flight and the flags still owed.
    // ------------------------------------------------------------------------
    class enc_flag_tracker;
        int         cap;
        logic [7:0] stored[$];
        bit         expected_flags[$];
        bit         overflowed;
        int         errors;
        int         packets;
        int         overflow_packets;
        int         results;
        int         raised;

        function new(int cap);
            this.cap = cap;
        endfunction

        // walks the table of the stored packet; 1 when the flag found is nonzero
        function bit walk_options();
            int         plen;
            int         pos;
            int         off;
            int         len;
            int         hdr;
            logic [7:0] kind;
            logic [7:0] flag;
            hdr = poc_pkg::HEADER_BYTES;
            if (stored.size() < hdr + 1) return 1'b0;
            plen = stored.size() - hdr;
            flag = poc_pkg::FLAG_RESET;
            pos  = 0;
            forever begin
                if (pos >= plen) return 1'b0;
                kind = stored[pos + hdr];
                if (kind == poc_pkg::END_TYPE) break;
                if (pos + poc_pkg::ENTRY_TAIL >= plen) return 1'b0;
                off = {stored[pos + hdr + 1], stored[pos + hdr + 2]};
                len = {stored[pos + hdr + 3], stored[pos + hdr + 4]};
                if (off > plen || off + len > plen) return 1'b0;
                if (kind == poc_pkg::ENCRYPT_TYPE && len >= 1) flag = stored[off + hdr];
                pos += poc_pkg::ENTRY_BYTES;
            end
            return flag != 8'h00;
        endfunction

        function void note_byte(poc_pkg::t_in_word w);
            if (stored.size() < cap) stored.push_back(w.data_byte);
            else overflowed = 1'b1;
            if (w.last_byte) begin
                expected_flags.push_back(walk_options());
                stored.delete();
                packets++;
                if (overflowed) overflow_packets++;
                overflowed = 1'b0;
            end
        endfunction

        function void check_result(poc_pkg::t_out_word w);
            bit want;
            if (expected_flags.size() == 0) begin
                $display("%0t: uses_encryption word with none expected, actual %0b",
                         $time, w.uses_encryption);
                errors++;
                return;
            end
            want = expected_flags.pop_front();
            results++;
            if (w.uses_encryption !== want) begin
                $display("%0t: uses_encryption expected %0b, actual %0b",
                         $time, want, w.uses_encryption);
                errors++;
            end else if (want) begin
                raised++;
            end
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    poc_stream_if #(.T(poc_pkg::t_in_word))  in_if ();
    poc_stream_if #(.T(poc_pkg::t_out_word)) out_if ();

    prelogin_encryption_option_check_core #(
        .MAX_PACKET_BYTES(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    enc_flag_tracker tracker = new(CAPACITY);

    int          burst_left;
    int          sent_bytes;
    logic [31:0] rx_cycle;

    always #2 i_clk = ~i_clk;

    // receiver: stall pattern follows bits 9:8 of the cycle counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_cycle     <= '0;
        end else begin
            rx_cycle <= rx_cycle + 32'd1;
            case (rx_cycle[9:8])
                2'd0: out_if.ready <= 1'b1;
                2'd1: out_if.ready <= 1'($urandom_range(0, 1));
                2'd2: out_if.ready <= (rx_cycle[2:0] == 3'd0);
                default: out_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) tracker.note_byte(in_if.data);
        if (i_rst_n && out_if.valid && out_if.ready) tracker.check_result(out_if.data);
    end

    // ------------------------------------------------------------------------
    // Packet building
    // ------------------------------------------------------------------------
    function automatic void start_packet(ref logic [7:0] p[$]);
        p.delete();
        repeat (poc_pkg::HEADER_BYTES) p.push_back(8'($urandom));
    endfunction

    function automatic void push_entry(ref logic [7:0] p[$], input logic [7:0] kind,
                                       input int off, input int len);
        p.push_back(kind);
        p.push_back(off[15:8]);
        p.push_back(off[7:0]);
        p.push_back(len[15:8]);
        p.push_back(len[7:0]);
    endfunction

    function automatic void build_random_packet(ref logic [7:0] p[$]);
        int         kind;
        int         n;
        int         d;
        int         plen;
        int         off;
        int         len;
        int         lim;
        int         cut;
        logic [7:0] t;
        kind = $urandom_range(0, 99);
        if (kind < 9) begin
            p.delete();
            repeat ($urandom_range(1, poc_pkg::HEADER_BYTES)) p.push_back(8'($urandom));
            return;
        end
        if (kind < 16) begin
            p.delete();
            repeat ($urandom_range(poc_pkg::HEADER_BYTES + 1, 40)) p.push_back(8'($urandom));
            return;
        end
        start_packet(p);
        n    = $urandom_range(0, 4);
        d    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 8);
        plen = n * poc_pkg::ENTRY_BYTES + 1 + d;
        for (int i = 0; i < n; i++) begin
            t = $urandom_range(0, 1) ? poc_pkg::ENCRYPT_TYPE : 8'($urandom);
            if (t == poc_pkg::END_TYPE) t = PLAIN_TYPE;
            if ($urandom_range(0, 7) != 0) begin
                off = $urandom_range(0, plen);
                lim = (plen - off < 3) ? plen - off : 3;
                len = $urandom_range(0, lim);
            end else begin
                off = $urandom_range(0, 16'hffff);
                len = $urandom_range(0, 16'hffff);
            end
            push_entry(p, t, off, len);
        end
        p.push_back(poc_pkg::END_TYPE);
        repeat (d) p.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
        // broken tables: lose the end mark or cut the packet short
        if (kind >= 84) begin
            if ($urandom_range(0, 1)) begin
                p[p.size() - d - 1] = 8'($urandom_range(0, 8'hfe));
            end else if (p.size() > poc_pkg::HEADER_BYTES + 1) begin
                cut = $urandom_range(poc_pkg::HEADER_BYTES + 1, p.size() - 1);
                while (p.size() > cut) void'(p.pop_back());
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic drive_byte(input logic [7:0] b, input bit last);
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (!in_if.ready);
        burst_left--;
        sent_bytes++;
    endtask

    task automatic send_packet(input logic [7:0] p[$]);
        foreach (p[i]) drive_byte(p[i], i == p.size() - 1);
    endtask

    // hold off until every owed flag has come back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic run_directed();
        logic [7:0] p[$];
        logic [7:0] flag_vals[3];
        flag_vals = '{8'h00, 8'h80, 8'hff};
        // short packets
        p = {8'h00};
        send_packet(p);
        start_packet(p);
        send_packet(p);
        // bare end mark, flag keeps its reset value
        start_packet(p);
        p.push_back(poc_pkg::END_TYPE);
        send_packet(p);
        // encryption flag zero, then 0x80, then 0xff
        foreach (flag_vals[k]) begin
            start_packet(p);
            push_entry(p, poc_pkg::ENCRYPT_TYPE, 6, 1);
            p.push_back(poc_pkg::END_TYPE);
            p.push_back(flag_vals[k]);
            send_packet(p);
        end
        // table runs off the end without an end mark
        start_packet(p);
        push_entry(p, PLAIN_TYPE, 0, 0);
        send_packet(p);
        // offset past the payload, offset plus length past the payload
        start_packet(p);
        push_entry(p, poc_pkg::ENCRYPT_TYPE, 16'hffff, 0);
        p.push_back(poc_pkg::END_TYPE);
        send_packet(p);
        start_packet(p);
        push_entry(p, poc_pkg::ENCRYPT_TYPE, 0, 16'hffff);
        p.push_back(poc_pkg::END_TYPE);
        send_packet(p);
        // zero-length encryption entry is ignored; offset equal to payload end
        start_packet(p);
        push_entry(p, poc_pkg::ENCRYPT_TYPE, 6, 0);
        p.push_back(poc_pkg::END_TYPE);
        send_packet(p);
        // last encryption entry wins
        start_packet(p);
        push_entry(p, poc_pkg::ENCRYPT_TYPE, 11, 1);
        push_entry(p, OTHER_TYPE, 12, 1);
        push_entry(p, poc_pkg::ENCRYPT_TYPE, 12, 1);
        p.push_back(poc_pkg::END_TYPE);
        p.push_back(8'h05);
        p.push_back(8'h00);
        send_packet(p);
        // entry cut off after its type and the high byte of its offset
        start_packet(p);
        p.push_back(poc_pkg::ENCRYPT_TYPE);
        p.push_back(8'h00);
        send_packet(p);
        // packet longer than the store; the last word is dropped but ends it
        start_packet(p);
        push_entry(p, poc_pkg::ENCRYPT_TYPE, 6, 1);
        p.push_back(poc_pkg::END_TYPE);
        p.push_back(8'hff);
        while (p.size() < CAPACITY + 6) p.push_back(8'h00);
        send_packet(p);
    endtask

    initial begin
        logic [7:0] p[$];
        int         random_end;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        burst_left   = 0;
        sent_bytes   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_results();

        random_end = sent_bytes + RANDOM_BYTES;
        while (sent_bytes < random_end) begin
            build_random_packet(p);
            send_packet(p);
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            $display("%0t: %0d uses_encryption words never arrived", $time, tracker.pending());
            tracker.errors++;
        end
        $display("%0d packets (%0d past store capacity), %0d bytes sent",
                 tracker.packets, tracker.overflow_packets, sent_bytes);
        $display("%0d result words checked, %0d with encryption set",
                 tracker.results, tracker.raised);
        if (tracker.errors == 0) begin
            $display("prelogin_encryption_option_check_core: match");
        end else begin
            $display("prelogin_encryption_option_check_core: mismatch");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("%0t: run timed out", $time);
        $display("prelogin_encryption_option_check_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
